// ===== sv/ppmfw_pkg.sv =====
// Shared constants, codes and types of the page-packed mono frame store writer.
`default_nettype none
package ppmfw_pkg;

   // Screen size in pixels
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;

   // Frame store geometry: eight pages of 128 column bytes
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = 10;
   localparam int PAGE_W      = 3;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 6;
   localparam int BYTE_W      = 8;

   // Request action codes
   localparam logic [2:0] ACT_OPEN  = 3'd0;
   localparam logic [2:0] ACT_FILL  = 3'd1;
   localparam logic [2:0] ACT_PIXEL = 3'd2;
   localparam logic [2:0] ACT_READ  = 3'd3;
   localparam logic [2:0] ACT_ACK   = 3'd4;

   // Request payload
   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] x_start;
      logic signed [15:0] y_start;
      logic signed [15:0] x_end;
      logic signed [15:0] y_end;
      logic               pixel_on;
      logic [PAGE_W-1:0]  read_page;
      logic [COL_W-1:0]   read_column;
   } req_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic clr_write;
      logic fill_init;
      logic fill_sel;
      logic pix_write;
      logic fill_write;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_pixel;
      logic is_fill;
      logic win_open;
      logic clip_ok;
      logic clr_last;
      logic fill_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/ppmfw_if.sv =====
// Request and response channel interfaces of the frame store writer.
`default_nettype none
interface ppmfw_req_if;
   import ppmfw_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [15:0] x_start;
   logic signed [15:0] y_start;
   logic signed [15:0] x_end;
   logic signed [15:0] y_end;
   logic               pixel_on;
   logic [PAGE_W-1:0]  read_page;
   logic [COL_W-1:0]   read_column;

   modport source (output valid, action, x_start, y_start, x_end, y_end, pixel_on,
                   read_page, read_column, input ready);
   modport sink (input valid, action, x_start, y_start, x_end, y_end, pixel_on,
                 read_page, read_column, output ready);
endinterface

interface ppmfw_rsp_if;
   import ppmfw_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic              redraw_needed;
   logic              window_done;

   modport source (output valid, read_data, redraw_needed, window_done, input ready);
   modport sink (input valid, read_data, redraw_needed, window_done, output ready);
endinterface
`default_nettype wire

// ===== sv/ppmfw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppmfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== sv/ppmfw_ctrl.sv =====
// Sequencing state machine of the frame store writer.
`default_nettype none
module ppmfw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ppmfw_pkg::sts_type sts,
   output ppmfw_pkg::cmd_type      cmd
);
   import ppmfw_pkg::*;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_DECODE  = 3'd2;
   localparam logic [2:0] ST_PIX_WR  = 3'd3;
   localparam logic [2:0] ST_FILL_RD = 3'd4;
   localparam logic [2:0] ST_FILL_WR = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Decode state into commands and pick the next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_pixel && sts.win_open) begin
               state_in = ST_PIX_WR;
            end else if (sts.is_fill && sts.clip_ok) begin
               cmd.fill_init = 1'b1;
               state_in      = ST_FILL_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_PIX_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_FILL_RD: begin
            cmd.fill_sel = 1'b1;
            state_in     = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            cmd.fill_sel   = 1'b1;
            cmd.fill_write = 1'b1;
            state_in       = sts.fill_last ? ST_EMIT : ST_FILL_RD;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/ppmfw_dp.sv =====
// Datapath of the frame store writer: request, window, cursor, fill walk, store, output.
`default_nettype none
module ppmfw_dp (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ppmfw_pkg::req_type        req,
   input  wire ppmfw_pkg::cmd_type        cmd,
   output ppmfw_pkg::sts_type             sts,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic [ppmfw_pkg::BYTE_W-1:0]   rsp_read_data,
   output logic                           rsp_redraw_needed,
   output logic                           rsp_window_done
);
   import ppmfw_pkg::*;

   localparam logic signed [15:0] X_MAX = 16'(SCREEN_WIDTH - 1);
   localparam logic signed [15:0] Y_MAX = 16'(SCREEN_HEIGHT - 1);

   req_type           req_ff;
   logic [COL_W-1:0]  win_left_ff, win_right_ff, cur_col_ff;
   logic [ROW_W-1:0]  win_top_ff, win_bottom_ff, cur_row_ff;
   logic              win_open_ff, redraw_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [PAGE_W-1:0] fill_page_ff;
   logic [COL_W-1:0]  fill_col_ff;
   logic              out_valid_ff, out_redraw_ff, out_done_ff;
   logic [BYTE_W-1:0] out_data_ff;

   logic              clip_off, clip_empty;
   logic signed [15:0] x1c, y1c, x2c, y2c;
   logic [COL_W-1:0]  clip_l, clip_r;
   logic [ROW_W-1:0]  clip_t, clip_b;
   logic [BYTE_W-1:0] fill_mask, pix_mask, wr_mask, rd_data, wr_data;
   logic [ADDR_W-1:0] cur_addr, fill_addr, rd_addr, wr_addr;
   logic              wr_en, out_free;

   // Latch the request on acceptance
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req;
      end
   end

   // Clip the requested rectangle to the screen
   always_comb begin
      clip_off = req_ff.x_end[15] || req_ff.y_end[15] ||
                 (req_ff.x_start > X_MAX) || (req_ff.y_start > Y_MAX);
      x1c = req_ff.x_start[15] ? 16'sd0 : req_ff.x_start;
      y1c = req_ff.y_start[15] ? 16'sd0 : req_ff.y_start;
      x2c = (req_ff.x_end > X_MAX) ? X_MAX : req_ff.x_end;
      y2c = (req_ff.y_end > Y_MAX) ? Y_MAX : req_ff.y_end;
      clip_l = x1c[COL_W-1:0];
      clip_r = x2c[COL_W-1:0];
      clip_t = y1c[ROW_W-1:0];
      clip_b = y2c[ROW_W-1:0];
      clip_empty = (clip_l > clip_r) || (clip_t > clip_b);
   end

   // Byte addresses and bit masks
   always_comb begin
      logic [ROW_W-1:0] row;
      cur_addr  = {cur_row_ff[ROW_W-1:3], cur_col_ff};
      fill_addr = {fill_page_ff, fill_col_ff};
      pix_mask  = BYTE_W'(1) << cur_row_ff[2:0];
      for (int i = 0; i < BYTE_W; i++) begin
         row          = {fill_page_ff, 3'(i)};
         fill_mask[i] = (row >= clip_t) && (row <= clip_b);
      end
   end

   // Select store read and write ports
   always_comb begin
      if (cmd.fill_sel) begin
         rd_addr = fill_addr;
      end else if (req_ff.action == ACT_PIXEL) begin
         rd_addr = cur_addr;
      end else begin
         rd_addr = {req_ff.read_page, req_ff.read_column};
      end
      wr_en   = cmd.clr_write || cmd.pix_write || cmd.fill_write;
      wr_addr = cmd.clr_write ? clr_cnt_ff : (cmd.pix_write ? cur_addr : fill_addr);
      wr_mask = cmd.pix_write ? pix_mask : fill_mask;
      if (cmd.clr_write) begin
         wr_data = '0;
      end else if (req_ff.pixel_on) begin
         wr_data = rd_data & ~wr_mask;
      end else begin
         wr_data = rd_data | wr_mask;
      end
   end

   ppmfw_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Advance the clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Walk the fill rectangle byte by byte, column first
   always_ff @(posedge clock) begin
      if (cmd.fill_init) begin
         fill_page_ff <= clip_t[ROW_W-1:3];
         fill_col_ff  <= clip_l;
      end else if (cmd.fill_write) begin
         if (fill_col_ff == clip_r) begin
            fill_col_ff  <= clip_l;
            fill_page_ff <= fill_page_ff + 1'b1;
         end else begin
            fill_col_ff <= fill_col_ff + 1'b1;
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   // Apply item effects and load the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_right_ff  <= '0;
         win_top_ff    <= '0;
         win_bottom_ff <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         win_open_ff   <= 1'b0;
         redraw_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= (req_ff.action == ACT_READ) ? rd_data : '0;
            out_redraw_ff <= redraw_ff;
            out_done_ff   <= 1'b0;
            case (req_ff.action)
               ACT_OPEN: begin
                  if (!clip_off && !clip_empty) begin
                     win_left_ff   <= clip_l;
                     win_right_ff  <= clip_r;
                     win_top_ff    <= clip_t;
                     win_bottom_ff <= clip_b;
                     cur_col_ff    <= clip_l;
                     cur_row_ff    <= clip_t;
                     win_open_ff   <= 1'b1;
                  end else begin
                     win_open_ff <= 1'b0;
                     out_done_ff <= 1'b1;
                  end
               end
               ACT_FILL: begin
                  out_done_ff <= 1'b1;
                  if (!clip_off) begin
                     redraw_ff     <= 1'b1;
                     out_redraw_ff <= 1'b1;
                  end
               end
               ACT_PIXEL: begin
                  if (win_open_ff) begin
                     redraw_ff     <= 1'b1;
                     out_redraw_ff <= 1'b1;
                     if (cur_col_ff >= win_right_ff) begin
                        cur_col_ff <= win_left_ff;
                        if (cur_row_ff >= win_bottom_ff) begin
                           win_open_ff <= 1'b0;
                           cur_row_ff  <= win_top_ff;
                           out_done_ff <= 1'b1;
                        end else begin
                           cur_row_ff <= cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_ff <= cur_col_ff + 1'b1;
                     end
                  end
               end
               ACT_ACK: begin
                  redraw_ff     <= 1'b0;
                  out_redraw_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Status toward the controller
   always_comb begin
      sts.is_pixel  = (req_ff.action == ACT_PIXEL);
      sts.is_fill   = (req_ff.action == ACT_FILL);
      sts.win_open  = win_open_ff;
      sts.clip_ok   = !clip_off && !clip_empty;
      sts.clr_last  = &clr_cnt_ff;
      sts.fill_last = (fill_col_ff == clip_r) && (fill_page_ff == clip_b[ROW_W-1:3]);
      sts.out_free  = out_free;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_data_ff;
   assign rsp_redraw_needed = out_redraw_ff;
   assign rsp_window_done   = out_done_ff;
endmodule
`default_nettype wire

// ===== sv/page_packed_mono_framebuffer_writer.sv =====
// Top level of the page-packed monochrome frame store writer.
//
// Requests enter on req_bus (valid/ready) and carry an action: open window,
// fill window, pixel, read byte or acknowledge. Every request returns exactly
// one response on rsp_bus with read_data, redraw_needed and window_done.
// The 1024-byte store is one RAM with registered read; pixel (column, row) is
// bit row%8 of byte (row/8)*128+column, and an on pixel clears its bit.
// Each request steps through controller states from accepting it to loading
// the response register; the next request can be accepted right after:
//   open, read, acknowledge, pixel with no window: accept, decode, emit
//   pixel inside an open window: accept, decode, write, emit; the write is
//   a read-modify-write of one byte
//   fill: accept, decode, a read and a write state per byte (columns * pages
//   touched) through the single store write port, then emit.
// One request is in flight at a time; the next is accepted once the current
// one has moved into the response register, even while that register waits.
// If the receiver stalls, the response holds and the block waits at the end
// of its next request until the register frees.
// After reset the block runs a clearing pass that zeroes the store
// with req_bus.ready low; window, cursor and redraw flag reset to zero.
`default_nettype none
module page_packed_mono_framebuffer_writer (
   input wire logic   clock,
   input wire logic   reset,
   ppmfw_req_if.sink  req_bus,
   ppmfw_rsp_if.source rsp_bus
);
   import ppmfw_pkg::*;

   req_type req;
   cmd_type cmd;
   sts_type sts;

   // Gather request payload
   always_comb begin
      req.action      = req_bus.action;
      req.x_start     = req_bus.x_start;
      req.y_start     = req_bus.y_start;
      req.x_end       = req_bus.x_end;
      req.y_end       = req_bus.y_end;
      req.pixel_on    = req_bus.pixel_on;
      req.read_page   = req_bus.read_page;
      req.read_column = req_bus.read_column;
   end

   ppmfw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   ppmfw_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_read_data    (rsp_bus.read_data),
      .rsp_redraw_needed(rsp_bus.redraw_needed),
      .rsp_window_done  (rsp_bus.window_done)
   );
endmodule
`default_nettype wire
